@@ src/hlsrgb_pkg.sv @@
// Shared constants and types for the HLS to RGB converter.
// No dependencies; imported by every module of the block.
package hlsrgb_pkg;

    // Fixed-point scaling of lightness and saturation
    localparam int FRAC_BITS = 12;

    // Port field widths
    localparam int HUE_W = 15;
    localparam int LS_W  = 13;
    localparam int CH_W  = 8;

    // Clamped lightness/saturation and the m1/m2 products (scaled by one*one)
    localparam int L_W   = FRAC_BITS + 1;
    localparam int CMP_W = (LS_W > L_W) ? LS_W : L_W;
    localparam int M_W   = 2 * FRAC_BITS + 1;
    localparam logic [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;
    localparam logic [CMP_W-1:0] HALF = CMP_W'(1) << (FRAC_BITS - 1);

    // Hue angles in 1/64 degree
    localparam logic [HUE_W-1:0] FULL_TURN = HUE_W'(23040);
    localparam logic [HUE_W-1:0] DEG60     = HUE_W'(3840);
    localparam logic [HUE_W-1:0] DEG120    = HUE_W'(7680);
    localparam logic [HUE_W-1:0] DEG180    = HUE_W'(11520);
    localparam logic [HUE_W-1:0] DEG240    = HUE_W'(15360);

    // Ramp position (0..3840) and the channel numerator
    localparam int SEG_W  = 12;
    localparam int PROD_W = M_W + SEG_W;

    // Numerator over 2^(2F) stays below 3841; divide by 15 with a reciprocal
    localparam int X_W         = 12;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(17477);
    localparam int RECIP_SHIFT = 18;
    localparam int QP_W        = X_W + RECIP_W;
    localparam int Q_W         = QP_W - RECIP_SHIFT;
    localparam logic [Q_W-1:0] CH_MAX = Q_W'(255);

    // Per-stage load enables from the top-level flow control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_load_t;

endpackage

@@ src/hlsrgb_front.sv @@
// Front end: clamps inputs, wraps the three channel hues, forms m1 and m2-m1.
// Depends on hlsrgb_pkg. Occupies pipeline stages 1 and 2.
module hlsrgb_front
    import hlsrgb_pkg::*;
(
    input  logic              clk,
    input  stage_load_t       ld,
    input  logic [HUE_W-1:0]  hue,
    input  logic [LS_W-1:0]   lightness,
    input  logic [LS_W-1:0]   saturation,
    output logic [HUE_W-1:0]  hue_red,
    output logic [HUE_W-1:0]  hue_green,
    output logic [HUE_W-1:0]  hue_blue,
    output logic [M_W-1:0]    m1,
    output logic [M_W-1:0]    diff
);

    logic [L_W-1:0]   l1_reg, l1_next;
    logic [L_W-1:0]   s1_reg, s1_next;
    logic [HUE_W-1:0] hr1_reg, hr1_next;
    logic [HUE_W-1:0] hg1_reg, hg1_next;
    logic [HUE_W-1:0] hb1_reg, hb1_next;

    logic [HUE_W-1:0] hr2_reg, hg2_reg, hb2_reg;
    logic [M_W-1:0]   m1_reg, m1_next;
    logic [M_W-1:0]   d_reg, d_next;

    logic [CMP_W-1:0] l_ext, s_ext;
    logic [HUE_W:0]   h_plus120, h_plus240;
    logic [2*L_W-1:0] ls_prod;
    logic [M_W:0]     l_sh, s_sh, m2_wide, m1_wide;
    logic [M_W-1:0]   m2_val;

    // Stage 1: saturate lightness/saturation to 1.0, wrap hues into one turn
    always_comb
    begin
        l_ext   = CMP_W'(lightness);
        s_ext   = CMP_W'(saturation);
        l1_next = (l_ext > ONE) ? L_W'(ONE) : L_W'(l_ext);
        s1_next = (s_ext > ONE) ? L_W'(ONE) : L_W'(s_ext);

        hg1_next = (hue >= FULL_TURN) ? hue - FULL_TURN : hue;
        h_plus120 = {1'b0, hg1_next} + {1'b0, DEG120};
        h_plus240 = {1'b0, hg1_next} + {1'b0, DEG240};
        hr1_next = (h_plus120 >= {1'b0, FULL_TURN}) ?
                   HUE_W'(h_plus120 - {1'b0, FULL_TURN}) : HUE_W'(h_plus120);
        hb1_next = (h_plus240 >= {1'b0, FULL_TURN}) ?
                   HUE_W'(h_plus240 - {1'b0, FULL_TURN}) : HUE_W'(h_plus240);
    end

    // Stage 2: m2 and m1 scaled by one*one, passed on as m1 and m2-m1
    always_comb
    begin
        ls_prod = l1_reg * s1_reg;
        l_sh    = (M_W+1)'(l1_reg) << FRAC_BITS;
        s_sh    = (M_W+1)'(s1_reg) << FRAC_BITS;
        if (CMP_W'(l1_reg) <= HALF)
        begin
            m2_wide = l_sh + (M_W+1)'(ls_prod);
        end
        else
        begin
            m2_wide = l_sh + s_sh - (M_W+1)'(ls_prod);
        end
        m2_val  = M_W'(m2_wide);
        m1_wide = (l_sh << 1) - m2_wide;
        m1_next = M_W'(m1_wide);
        d_next  = m2_val - m1_next;
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            l1_reg  <= l1_next;
            s1_reg  <= s1_next;
            hr1_reg <= hr1_next;
            hg1_reg <= hg1_next;
            hb1_reg <= hb1_next;
        end
        if (ld.s2)
        begin
            hr2_reg <= hr1_reg;
            hg2_reg <= hg1_reg;
            hb2_reg <= hb1_reg;
            m1_reg  <= m1_next;
            d_reg   <= d_next;
        end
    end

    assign hue_red   = hr2_reg;
    assign hue_green = hg2_reg;
    assign hue_blue  = hb2_reg;
    assign m1        = m1_reg;
    assign diff      = d_reg;

endmodule

@@ src/hlsrgb_channel.sv @@
// One color channel: piecewise linear hue function, scale to 8 bits, clamp.
// Depends on hlsrgb_pkg. Occupies pipeline stages 3, 4 and 5.
module hlsrgb_channel
    import hlsrgb_pkg::*;
(
    input  logic              clk,
    input  stage_load_t       ld,
    input  logic [HUE_W-1:0]  hue_ch,
    input  logic [M_W-1:0]    m1,
    input  logic [M_W-1:0]    diff,
    output logic [CH_W-1:0]   value
);

    logic [SEG_W-1:0]  ramp;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] base_reg, base_next;
    logic [PROD_W-1:0] num;
    logic [X_W-1:0]    x_reg, x_next;
    logic [QP_W-1:0]   qp;
    logic [Q_W-1:0]    q;
    logic [CH_W-1:0]   val_reg, val_next;

    // Stage 3: ramp position for the hue segment, (m2-m1)*ramp and m1*60deg
    always_comb
    begin
        priority if (hue_ch < DEG60)
        begin
            ramp = SEG_W'(hue_ch);
        end
        else if (hue_ch < DEG180)
        begin
            ramp = SEG_W'(DEG60);
        end
        else if (hue_ch < DEG240)
        begin
            ramp = SEG_W'(DEG240 - hue_ch);
        end
        else
        begin
            ramp = '0;
        end
        prod_next = PROD_W'(diff) * PROD_W'(ramp);
        base_next = PROD_W'(m1) * PROD_W'(DEG60);
    end

    // Stage 4: numerator, drop the one*one scale (256 cancels against 60deg)
    always_comb
    begin
        num    = base_reg + prod_reg;
        x_next = num[2*FRAC_BITS +: X_W];
    end

    // Stage 5: divide by 15 through the reciprocal, saturate at 255
    always_comb
    begin
        qp       = QP_W'(x_reg) * QP_W'(RECIP);
        q        = qp[RECIP_SHIFT +: Q_W];
        val_next = (q > CH_MAX) ? CH_W'(CH_MAX) : CH_W'(q);
    end

    always_ff @(posedge clk)
    begin
        if (ld.s3)
        begin
            prod_reg <= prod_next;
            base_reg <= base_next;
        end
        if (ld.s4)
        begin
            x_reg <= x_next;
        end
        if (ld.s5)
        begin
            val_reg <= val_next;
        end
    end

    assign value = val_reg;

endmodule

@@ src/hls_to_rgb_converter.sv @@
// HLS to RGB converter, five-stage pipeline: throughput one color per cycle
// while the output is not stalled.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under output stall.
// Reset (rst_n, async active low) clears only the stage valid bits.
// Depends on hlsrgb_pkg, hlsrgb_front and hlsrgb_channel.
module hls_to_rgb_converter
    import hlsrgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [HUE_W-1:0]  hue,
    input  logic [LS_W-1:0]   lightness,
    input  logic [LS_W-1:0]   saturation,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CH_W-1:0]   red,
    output logic [CH_W-1:0]   green,
    output logic [CH_W-1:0]   blue
);

    logic [4:0]       valid_reg, valid_next;
    stage_load_t      ld;
    logic [HUE_W-1:0] hue_red, hue_green, hue_blue;
    logic [M_W-1:0]   m1, diff;

    // Load enables ripple back from the output
    always_comb
    begin
        ld.s5 = !valid_reg[4] || !out_stall;
        ld.s4 = !valid_reg[3] || ld.s5;
        ld.s3 = !valid_reg[2] || ld.s4;
        ld.s2 = !valid_reg[1] || ld.s3;
        ld.s1 = !valid_reg[0] || ld.s2;

        valid_next[0] = ld.s1 ? in_valid     : valid_reg[0];
        valid_next[1] = ld.s2 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = ld.s3 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = ld.s4 ? valid_reg[2] : valid_reg[3];
        valid_next[4] = ld.s5 ? valid_reg[3] : valid_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !ld.s1;
    assign out_valid = valid_reg[4];

    hlsrgb_front u_front
    (
        .clk        (clk),
        .ld         (ld),
        .hue        (hue),
        .lightness  (lightness),
        .saturation (saturation),
        .hue_red    (hue_red),
        .hue_green  (hue_green),
        .hue_blue   (hue_blue),
        .m1         (m1),
        .diff       (diff)
    );

    hlsrgb_channel u_red
    (
        .clk    (clk),
        .ld     (ld),
        .hue_ch (hue_red),
        .m1     (m1),
        .diff   (diff),
        .value  (red)
    );

    hlsrgb_channel u_green
    (
        .clk    (clk),
        .ld     (ld),
        .hue_ch (hue_green),
        .m1     (m1),
        .diff   (diff),
        .value  (green)
    );

    hlsrgb_channel u_blue
    (
        .clk    (clk),
        .ld     (ld),
        .hue_ch (hue_blue),
        .m1     (m1),
        .diff   (diff),
        .value  (blue)
    );

endmodule

@@ verif/hls_to_rgb_converter_test.sv @@
// Self-checking testbench for hls_to_rgb_converter: directed corner colors,
// then random HLS colors with random idling on both channels.
// Depends on hlsrgb_pkg and the hls_to_rgb_converter RTL.
`timescale 1ns / 1ps

module hls_to_rgb_converter_test;
    import hlsrgb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_COLORS = 1930;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [LS_W-1:0]  lightness;
        logic [LS_W-1:0]  saturation;
    } hls_t;

    // Predicts the RGB of each accepted color and checks results in order
    class hls_rgb_tracker;
        rgb_t        pending_rgb[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int unsigned wrap_turn(int unsigned h);
            return (h >= FULL_TURN) ? h - FULL_TURN : h;
        endfunction

        // Piecewise linear channel, m1/m2 scaled by one*one, floor(256*x) capped
        function logic [CH_W-1:0] ramp_level(longint unsigned m1, longint unsigned m2,
                                             int unsigned h);
            longint unsigned span;
            longint unsigned num;
            longint unsigned den;
            longint unsigned q;
            span = m2 - m1;
            den  = (longint'(1) << (2 * FRAC_BITS)) * DEG60;
            if (h < DEG60)
                num = m1 * DEG60 + span * h;
            else if (h < DEG180)
                num = m2 * DEG60;
            else if (h < DEG240)
                num = m1 * DEG60 + span * (DEG240 - h);
            else
                num = m1 * DEG60;
            q = (num * 256) / den;
            if (q > 255)
                q = 255;
            return q[CH_W-1:0];
        endfunction

        function void note_input(logic [HUE_W-1:0] hue_in, logic [LS_W-1:0] l_in,
                                 logic [LS_W-1:0] s_in);
            longint unsigned one_v;
            longint unsigned lv;
            longint unsigned sv;
            longint unsigned m1;
            longint unsigned m2;
            int unsigned     h;
            rgb_t            want;
            one_v = longint'(1) << FRAC_BITS;
            lv = (l_in > one_v) ? one_v : l_in;
            sv = (s_in > one_v) ? one_v : s_in;
            h  = wrap_turn(hue_in);
            // m2 and m1 of the double cone
            if (2 * lv <= one_v)
                m2 = lv * (one_v + sv);
            else
                m2 = lv * one_v + sv * one_v - lv * sv;
            m1 = 2 * lv * one_v - m2;
            want.red   = ramp_level(m1, m2, wrap_turn(h + DEG120));
            want.green = ramp_level(m1, m2, h);
            want.blue  = ramp_level(m1, m2, wrap_turn(h + (FULL_TURN - DEG120)));
            pending_rgb.push_back(want);
        endfunction

        function void check_result(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                   logic [CH_W-1:0] b);
            rgb_t want;
            if (pending_rgb.size() == 0)
            begin
                $error("unexpected result: red %0d green %0d blue %0d", r, g, b);
                mismatches++;
                return;
            end
            want = pending_rgb.pop_front();
            if (r !== want.red)
            begin
                $error("red: expected %0d, got %0d", want.red, r);
                mismatches++;
            end
            if (g !== want.green)
            begin
                $error("green: expected %0d, got %0d", want.green, g);
                mismatches++;
            end
            if (b !== want.blue)
            begin
                $error("blue: expected %0d, got %0d", want.blue, b);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [HUE_W-1:0] hue;
    logic [LS_W-1:0]  lightness;
    logic [LS_W-1:0]  saturation;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    hls_rgb_tracker tracker;
    bit             in_steady  = 1'b0;
    bit             out_steady = 1'b0;
    int unsigned    stall_left = 0;
    int unsigned    idle_cycles = 0;

    hls_t directed_colors[20] = '{
        '{15'd0,     13'd0,    13'd0},     // black
        '{15'd0,     13'd4096, 13'd0},     // white
        '{15'd0,     13'd2048, 13'd4096},  // pure red, channel at exactly 1.0
        '{15'd7680,  13'd2048, 13'd4096},  // pure green
        '{15'd15360, 13'd2048, 13'd4096},  // pure blue
        '{15'd3839,  13'd2048, 13'd4096},
        '{15'd3840,  13'd1024, 13'd2048},
        '{15'd11519, 13'd3000, 13'd4096},
        '{15'd11520, 13'd2049, 13'd4096},
        '{15'd19200, 13'd2047, 13'd1},
        '{15'd23039, 13'd4095, 13'd4095},
        '{15'd23040, 13'd2048, 13'd4096},  // hue of a full turn wraps to zero
        '{15'd32767, 13'd1500, 13'd3500},  // largest hue code
        '{15'd30720, 13'd8191, 13'd8191},  // both above 1.0, clamped
        '{15'd1000,  13'd4097, 13'd100},
        '{15'd5000,  13'd2500, 13'd8191},
        '{15'd16383, 13'd4096, 13'd4096},
        '{15'd21845, 13'd5461, 13'd2730},  // alternating bit patterns
        '{15'd10922, 13'd2730, 13'd5461},
        '{15'd1,     13'd1,    13'd1}
    };

    hls_to_rgb_converter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .lightness  (lightness),
        .saturation (saturation),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #4 clk = ~clk;

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Result side: random stall bursts, checked on every transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(red, green, blue);
        if (stall_left == 0 && !out_steady)
            stall_left = pick_idle();
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** hls_to_rgb_converter: FAILED **");
            $finish;
        end
    end

    // Present one color after a random gap and hold it until the transfer
    task automatic send_color(hls_t c);
        int unsigned gap;
        gap = in_steady ? 0 : pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hue        <= c.hue;
        lightness  <= c.lightness;
        saturation <= c.saturation;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_input(c.hue, c.lightness, c.saturation);
    endtask

    // Sender idles until every pending result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending_rgb.size() != 0)
            @(posedge clk);
    endtask

    function automatic hls_t random_color();
        hls_t        c;
        int unsigned r;
        int unsigned corner;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            // in-range colors
            c.hue        = HUE_W'($urandom_range(0, 23039));
            c.lightness  = LS_W'($urandom_range(0, 4096));
            c.saturation = LS_W'($urandom_range(0, 4096));
        end
        else if (r < 7)
        begin
            // hue right at a segment edge, lightness near one half
            corner       = 3840 * $urandom_range(0, 6);
            c.hue        = HUE_W'(corner + $urandom_range(0, 2) - 1);
            c.lightness  = LS_W'($urandom_range(2040, 2056));
            c.saturation = LS_W'($urandom_range(0, 4096));
        end
        else
        begin
            // whole field widths, hue wrap and clamping
            c.hue        = HUE_W'($urandom_range(0, 32767));
            c.lightness  = LS_W'($urandom_range(0, 8191));
            c.saturation = LS_W'($urandom_range(0, 8191));
        end
        return c;
    endfunction

    initial
    begin
        int i;
        tracker    = new();
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        hue        <= '0;
        lightness  <= '0;
        saturation <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners
        for (i = 0; i < 20; i++)
            send_color(directed_colors[i]);

        // Random colors, with full drains and stretches without idling
        for (i = 0; i < RANDOM_COLORS; i++)
        begin
            if (i == 600)
                drain_results();
            if (i == 900)
            begin
                in_steady  = 1'b1;
                out_steady = 1'b1;
            end
            if (i == 1100)
            begin
                in_steady  = 1'b0;
                out_steady = 1'b0;
            end
            if (i == 1400)
            begin
                out_steady = 1'b1;
                drain_results();
            end
            if (i == 1600)
                out_steady = 1'b0;
            send_color(random_color());
        end

        // Drain and let the pipeline settle
        in_valid <= 1'b0;
        while (tracker.pending_rgb.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_rgb.size() == 0)
            $display("** hls_to_rgb_converter: PASSED **");
        else
            $display("** hls_to_rgb_converter: FAILED **");
        $finish;
    end

endmodule
